>>> rtl/bounded_ordered_list_editor_macros.svh
// assertion helpers for the list editor
`ifndef BOUNDED_ORDERED_LIST_EDITOR_MACROS_SVH
`define BOUNDED_ORDERED_LIST_EDITOR_MACROS_SVH

`ifndef SYNTHESIS
`define BOLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BOLE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BOLE_ASSERT(lbl, prop, msg)
`define BOLE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/bole_pkg.sv
`default_nettype none
package bole_pkg;
	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int LOC_W  = 7;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [LOC_W-1:0] loc_t;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_END   = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_END   = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_DISPLAY   = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_INVALID = 2'd2,
		STAT_FULL    = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INS,
		CM_DEL,
		CM_ROT
	} mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_SHOW
	} state_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		mode_t mode;
		idx_t  pos;
	} cmd_t;
endpackage
`default_nettype wire

>>> rtl/bole_if.sv
`default_nettype none
interface bole_in_if;
	import bole_pkg::*;
	logic  valid;
	logic  ready;
	logic [2:0] op;
	data_t item;
	loc_t  loc;
	modport source (output valid, output op, output item, output loc, input ready);
	modport sink (input valid, input op, input item, input loc, output ready);
endinterface

interface bole_out_if;
	import bole_pkg::*;
	logic  valid;
	logic  ready;
	logic [1:0] status;
	data_t value;
	logic  last;
	modport source (output valid, output status, output value, output last, input ready);
	modport sink (input valid, input status, input value, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/bole_cell.sv
`default_nettype none
module bole_cell (
	input  wire logic          clk,
	input  wire bole_pkg::idx_t  idx,
	input  wire bole_pkg::cmd_t  cmd,
	input  wire bole_pkg::data_t item,
	input  wire bole_pkg::data_t prev_val,
	input  wire bole_pkg::data_t next_val,
	input  wire bole_pkg::data_t head_val,
	output bole_pkg::data_t      val
);
	import bole_pkg::*;

	data_t val_q;
	data_t val_d;

	always_comb begin
		val_d = val_q;
		case (cmd.mode)
			CM_INS: begin
				if (idx > cmd.pos)
					val_d = prev_val;
				else if (idx == cmd.pos)
					val_d = item;
			end
			CM_DEL: begin
				if (idx >= cmd.pos)
					val_d = next_val;
			end
			CM_ROT: begin
				// pos marks the tail; the front wraps round to it
				if (idx < cmd.pos)
					val_d = next_val;
				else if (idx == cmd.pos)
					val_d = head_val;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;
endmodule
`default_nettype wire

>>> rtl/bole_ctrl.sv
`default_nettype none
module bole_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	bole_in_if.sink              in_ch,
	bole_out_if.source           out_ch,
	input  wire bole_pkg::data_t head_val,
	output bole_pkg::cmd_t       cmd,
	output bole_pkg::data_t      item,
	output bole_pkg::cnt_t       cnt
);
	import bole_pkg::*;

	state_t state_q, state_d;
	cnt_t   cnt_q, cnt_d;
	idx_t   shw_q, shw_d;
	logic   ovalid_q, ovalid_d;
	stat_t  ostat_q, ostat_d;
	data_t  oval_q, oval_d;
	logic   olast_q, olast_d;

	logic   out_free;
	logic   take;
	logic   emit;
	loc_t   ipos;
	loc_t   dpos;
	loc_t   cnt_ext;
	idx_t   tail;

	assign out_free = !ovalid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign take = in_ch.valid && in_ch.ready;
	assign cnt_ext = LOC_W'(cnt_q);
	assign tail = IDX_W'(cnt_q - CNT_W'(1));

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		shw_d    = shw_q;
		emit     = 1'b0;
		ostat_d  = ostat_q;
		oval_d   = oval_q;
		olast_d  = olast_q;
		cmd.mode = CM_HOLD;
		cmd.pos  = '0;
		ipos     = '0;
		dpos     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (op_t'(in_ch.op))
						OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
							if (op_t'(in_ch.op) == OP_INS_FRONT)
								ipos = '0;
							else if (op_t'(in_ch.op) == OP_INS_END)
								ipos = cnt_ext;
							else
								ipos = in_ch.loc;
							emit    = 1'b1;
							oval_d  = '0;
							olast_d = 1'b1;
							if (cnt_q == CNT_W'(DEPTH)) begin
								ostat_d = STAT_FULL;
							end else if (ipos > cnt_ext) begin
								ostat_d = STAT_INVALID;
							end else begin
								ostat_d  = STAT_OK;
								cmd.mode = CM_INS;
								cmd.pos  = IDX_W'(ipos);
								cnt_d    = cnt_q + CNT_W'(1);
							end
						end
						OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
							if (op_t'(in_ch.op) == OP_DEL_FRONT)
								dpos = '0;
							else if (op_t'(in_ch.op) == OP_DEL_END)
								dpos = LOC_W'(tail);
							else
								dpos = in_ch.loc;
							emit    = 1'b1;
							oval_d  = '0;
							olast_d = 1'b1;
							if (cnt_q == '0) begin
								ostat_d = STAT_EMPTY;
							end else if (dpos >= cnt_ext) begin
								ostat_d = STAT_INVALID;
							end else begin
								ostat_d  = STAT_OK;
								cmd.mode = CM_DEL;
								cmd.pos  = IDX_W'(dpos);
								cnt_d    = cnt_q - CNT_W'(1);
							end
						end
						OP_DISPLAY: begin
							if (cnt_q == '0) begin
								emit    = 1'b1;
								ostat_d = STAT_EMPTY;
								oval_d  = '0;
								olast_d = 1'b1;
							end else begin
								state_d = ST_SHOW;
								shw_d   = '0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SHOW: begin
				// front cell goes out while the chain rotates by one
				if (out_free) begin
					emit     = 1'b1;
					ostat_d  = STAT_OK;
					oval_d   = head_val;
					olast_d  = (shw_q == tail);
					cmd.mode = CM_ROT;
					cmd.pos  = tail;
					shw_d    = shw_q + IDX_W'(1);
					if (shw_q == tail)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (emit)
			ovalid_d = 1'b1;
		else if (out_ch.ready)
			ovalid_d = 1'b0;
		else
			ovalid_d = ovalid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			shw_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			shw_q    <= shw_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		ostat_q <= ostat_d;
		oval_q  <= oval_d;
		olast_q <= olast_d;
	end

	assign out_ch.valid  = ovalid_q;
	assign out_ch.status = ostat_q;
	assign out_ch.value  = oval_q;
	assign out_ch.last   = olast_q;
	assign item = in_ch.item;
	assign cnt  = cnt_q;
endmodule
`default_nettype wire

>>> rtl/bounded_ordered_list_editor.sv
// insert and delete: result registered and offered in the cycle after the request is taken
// display: the sequencer starts, then one stored value per cycle while the output is taken,
// paced by the single output register as the cell chain rotates its front value out
// back-to-back insert and delete requests run at one per cycle while the output is taken
// reset clears the count, the sequencer and the output valid; cell contents stay undefined
`default_nettype none
`include "bounded_ordered_list_editor_macros.svh"
module bounded_ordered_list_editor (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bole_in_if.sink    in_ch,
	bole_out_if.source out_ch
);
	import bole_pkg::*;

	cmd_t  cmd;
	data_t item;
	cnt_t  cnt;
	data_t vals [DEPTH];

	bole_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.head_val (vals[0]),
		.cmd      (cmd),
		.item     (item),
		.cnt      (cnt)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		data_t prev_v;
		data_t next_v;
		if (i == 0) begin : g_first
			assign prev_v = item;
		end else begin : g_mid_prev
			assign prev_v = vals[i-1];
		end
		if (i == DEPTH - 1) begin : g_final
			assign next_v = '0;
		end else begin : g_mid_next
			assign next_v = vals[i+1];
		end
		bole_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(i)),
			.cmd      (cmd),
			.item     (item),
			.prev_val (prev_v),
			.next_val (next_v),
			.head_val (vals[0]),
			.val      (vals[i])
		);
	end

	`BOLE_ASSERT(a_cnt_bound, cnt <= CNT_W'(DEPTH), "count beyond depth")
	`BOLE_ASSERT(a_ready_free,
		in_ch.ready |-> (!out_ch.valid || out_ch.ready),
		"request taken while result blocked")
	`BOLE_ASSERT(a_cnt_step,
		(cnt == $past(cnt)) || (cnt == $past(cnt) + CNT_W'(1)) || (cnt + CNT_W'(1) == $past(cnt)),
		"count moved by more than one")
	`BOLE_ASSERT_RST(a_rst_idle, !arst_n |-> !out_ch.valid, "result valid during reset")
endmodule
`default_nettype wire

>>> test/tb_bounded_ordered_list_editor.sv
`default_nettype none
module tb_bounded_ordered_list_editor;
	timeunit 1ns;
	timeprecision 1ps;

	import bole_pkg::*;

	// op code with no meaning, the block drops it
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int IDLE_PCT = 38;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int PRINT_CAP = 200;

	typedef struct packed {
		stat_t status;
		data_t value;
		logic  last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	bole_in_if  req_if ();
	bole_out_if rsp_if ();

	bounded_ordered_list_editor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_if),
		.out_ch (rsp_if)
	);

	always #5 clk = ~clk;

	data_t   list_model[$];
	result_t pending_results[$];
	int      mismatches = 0;
	int      quiet_cycles = 0;
	int      hold_left = 0;
	bit      hold_go = 1'b0;
	bit      steady = 1'b0;

	function automatic void push_result(stat_t status, data_t value, logic last);
		result_t r;
		r.status = status;
		r.value  = value;
		r.last   = last;
		pending_results.push_back(r);
	endfunction

	function automatic stat_t insert_value(int pos, data_t value);
		if (list_model.size() >= DEPTH)
			return STAT_FULL;
		if (pos > list_model.size())
			return STAT_INVALID;
		list_model.insert(pos, value);
		return STAT_OK;
	endfunction

	function automatic stat_t remove_value(int pos);
		if (list_model.size() == 0)
			return STAT_EMPTY;
		if (pos >= list_model.size())
			return STAT_INVALID;
		list_model.delete(pos);
		return STAT_OK;
	endfunction

	// works out the results one accepted request causes
	function automatic void predict_request(logic [2:0] op, data_t item, loc_t loc);
		int n;
		n = list_model.size();
		case (op)
			OP_INS_FRONT: push_result(insert_value(0, item), '0, 1'b1);
			OP_INS_END:   push_result(insert_value(n, item), '0, 1'b1);
			OP_INS_AT:    push_result(insert_value(int'(loc), item), '0, 1'b1);
			OP_DEL_FRONT: push_result(remove_value(0), '0, 1'b1);
			OP_DEL_END:   push_result(remove_value(n == 0 ? 0 : n - 1), '0, 1'b1);
			OP_DEL_AT:    push_result(remove_value(int'(loc)), '0, 1'b1);
			OP_DISPLAY: begin
				if (n == 0)
					push_result(STAT_EMPTY, '0, 1'b1);
				else
					for (int i = 0; i < n; i++)
						push_result(STAT_OK, list_model[i], i == n - 1);
			end
			default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
	endfunction

	// receiver: random idling, plus a long hold when asked for
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t ns: unexpected result: expected none, actual status %0d value %0h last %0b",
						$time, rsp_if.status, rsp_if.value, rsp_if.last);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.status !== want.status)
					note_mismatch("status", 32'(want.status), 32'(rsp_if.status));
				if (rsp_if.value !== want.value)
					note_mismatch("value", want.value, rsp_if.value);
				if (rsp_if.last !== want.last)
					note_mismatch("last", 32'(want.last), 32'(rsp_if.last));
			end
		end
	end

	// watchdog on cycles where neither side moves anything
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: stuck for %0d cycles with %0d results outstanding",
				$time, quiet_cycles, pending_results.size());
			$display("tb_bounded_ordered_list_editor: done, errors");
			$finish;
		end
	end

	task automatic send_request(input logic [2:0] op, input data_t item, input loc_t loc);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_if.valid <= 1'b1;
		req_if.op    <= op;
		req_if.item  <= item;
		req_if.loc   <= loc;
		do @(posedge clk); while (!req_if.ready);
		predict_request(op, item, loc);
	endtask

	task automatic wait_for_results();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_empty_list();
		send_request(OP_DISPLAY, '0, '0);
		send_request(OP_DEL_FRONT, '0, '0);
		send_request(OP_DEL_END, '0, '0);
		send_request(OP_DEL_AT, '0, 7'd127);
		send_request(OP_INS_AT, 32'sd5, 7'd1);
		send_request(OP_UNUSED, 32'sh7fff_ffff, 7'd127);
	endtask

	task automatic test_list_edges();
		send_request(OP_INS_FRONT, 32'sh8000_0000, '0);
		send_request(OP_INS_END, 32'sh7fff_ffff, '0);
		send_request(OP_INS_AT, -32'sd1, 7'd1);
		// position equal to the count appends
		send_request(OP_INS_AT, '0, 7'd3);
		send_request(OP_INS_AT, 32'sd9, 7'd5);
		send_request(OP_DEL_AT, '0, 7'd4);
		send_request(OP_DEL_AT, '0, 7'd127);
		send_request(OP_DISPLAY, '0, '0);
		while (list_model.size() < DEPTH)
			send_request(OP_INS_AT, data_t'($urandom), loc_t'(list_model.size() / 2));
		// full wins over a bad position
		send_request(OP_INS_AT, 32'sd1, 7'd127);
		send_request(OP_INS_FRONT, 32'sd2, '0);
		send_request(OP_DISPLAY, '0, '0);
		send_request(OP_DEL_AT, '0, 7'd7);
		send_request(OP_DEL_FRONT, '0, '0);
		send_request(OP_DEL_END, '0, '0);
		send_request(OP_UNUSED, '0, '0);
	endtask

	task automatic test_random_edits(input int n, input int grow_pct);
		int sent;
		int pick;
		int sz;
		logic [2:0] op;
		loc_t loc;
		data_t val;
		sent = 0;
		while (sent < n) begin
			sz = list_model.size();
			pick = $urandom_range(0, 99);
			if (pick < 8)
				op = OP_DISPLAY;
			else if (pick < 10)
				op = OP_UNUSED;
			else if (pick < 10 + grow_pct * 90 / 100)
				op = 3'($urandom_range(OP_INS_FRONT, OP_INS_AT));
			else
				op = 3'($urandom_range(OP_DEL_FRONT, OP_DEL_AT));
			if ($urandom_range(0, 9) == 0)
				loc = loc_t'($urandom_range(0, 127));
			else
				loc = loc_t'($urandom_range(0, sz + 1));
			case ($urandom_range(0, 7))
				0: val = 32'sh8000_0000;
				1: val = 32'sh7fff_ffff;
				default: val = data_t'($urandom);
			endcase
			send_request(op, val, loc);
			if (op != OP_UNUSED)
				sent++;
		end
	endtask

	task automatic test_output_stall();
		hold_go = 1'b1;
		test_random_edits(40, 75);
		// then let the block empty out completely before going on
		wait_for_results();
		test_random_edits(20, 50);
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		test_random_edits(60, 50);
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = OP_INS_FRONT;
		req_if.item = '0;
		req_if.loc = '0;
		rsp_if.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_list_edges();
		test_random_edits(150, 70);
		test_random_edits(150, 30);
		test_output_stall();
		test_back_to_back();
		test_random_edits(80, 50);

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_bounded_ordered_list_editor: done, clean");
		else
			$display("tb_bounded_ordered_list_editor: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/bole_pkg.sv
rtl/bole_if.sv
rtl/bole_cell.sv
rtl/bole_ctrl.sv
rtl/bounded_ordered_list_editor.sv
test/tb_bounded_ordered_list_editor.sv
